// ===== src/slow_pwm_with_min_pulse_defines.svh =====
// ----------------------------------------------------------------------------
// slow_pwm_with_min_pulse_defines.svh
// Assertion macros shared by the slow PWM block.
// ----------------------------------------------------------------------------
`ifndef SLOW_PWM_WITH_MIN_PULSE_DEFINES_SVH
`define SLOW_PWM_WITH_MIN_PULSE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define SPWM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define SPWM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/spwm_pkg.sv =====
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared widths, constants, types and helpers of the slow PWM block.
// ----------------------------------------------------------------------------
package spwm_pkg;

  localparam int unsigned DUTY_W    = 18;  // signed Q1.16 request
  localparam int unsigned DUTY_CW   = 17;  // clamped duty, 0..65536
  localparam int unsigned FRAC_W    = 16;  // fraction bits of the duty
  localparam int unsigned TIME_W    = 32;  // millisecond time
  localparam int unsigned CFG_W     = 16;  // register data width
  localparam int unsigned CFG_IDX_W = 2;   // register index width
  localparam int unsigned MS_W      = 26;  // 65535 s in ms fits 26 bits
  localparam int unsigned PROD_W    = DUTY_CW + MS_W;

  localparam logic [DUTY_CW-1:0] DUTY_ONE = DUTY_CW'(65536);
  localparam int unsigned        MS_PER_S = 1000;

  localparam logic [MS_W-1:0] PERIOD_RST_MS  = MS_W'(10 * MS_PER_S);
  localparam logic [MS_W-1:0] MIN_DUR_RST_MS = MS_W'(1 * MS_PER_S);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_MIN_DUR = 2'd1
  } cfg_reg_e;

  // Interval word handed from the multiply stage to the phase machine
  typedef struct packed {
    logic [MS_W-1:0]   on_ms;
    logic [MS_W-1:0]   off_ms;
    logic [TIME_W-1:0] now_ms;
  } interval_t;

  // Clamp a signed Q1.16 duty to 0..1.0
  function automatic logic [DUTY_CW-1:0] clamp_duty(input logic [DUTY_W-1:0] raw);
    logic [DUTY_CW-1:0] res;
    if (raw[DUTY_W-1]) begin
      res = '0;
    end else if (raw[DUTY_CW-1:0] > DUTY_ONE) begin
      res = DUTY_ONE;
    end else begin
      res = raw[DUTY_CW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/spwm_cfg.sv =====
// ----------------------------------------------------------------------------
// spwm_cfg
// Configuration registers, kept in milliseconds.
// ----------------------------------------------------------------------------
module spwm_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spwm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic [spwm_pkg::MS_W-1:0]      period_ms_o,
  output logic [spwm_pkg::MS_W-1:0]      min_ms_o
);
  import spwm_pkg::*;

  logic [MS_W-1:0] period_ms_q, period_ms_d;
  logic [MS_W-1:0] min_ms_q, min_ms_d;
  logic [MS_W-1:0] wdata_ms;

  // Scale seconds to milliseconds on the write
  assign wdata_ms = MS_W'(cfg_wdata_i) * MS_W'(MS_PER_S);

  // Decode the write; unknown indexes are dropped
  always_comb begin
    period_ms_d = period_ms_q;
    min_ms_d    = min_ms_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD:  period_ms_d = wdata_ms;
        CFG_MIN_DUR: min_ms_d    = wdata_ms;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ms_q <= PERIOD_RST_MS;
      min_ms_q    <= MIN_DUR_RST_MS;
    end else begin
      period_ms_q <= period_ms_d;
      min_ms_q    <= min_ms_d;
    end
  end

  assign period_ms_o = period_ms_q;
  assign min_ms_o    = min_ms_q;

endmodule

// ===== src/spwm_split.sv =====
// ----------------------------------------------------------------------------
// spwm_split
// Input register and on/off interval split of the period.
// ----------------------------------------------------------------------------
module spwm_split (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spwm_pkg::DUTY_W-1:0]   duty_i,
  input  logic [spwm_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [spwm_pkg::MS_W-1:0]     period_ms_i,
  output logic                          ivl_valid_o,
  input  logic                          ivl_ready_i,
  output spwm_pkg::interval_t           ivl_o
);
  import spwm_pkg::*;

  logic               in_v_q, in_v_d;
  logic [DUTY_CW-1:0] duty_q;
  logic [TIME_W-1:0]  now_q;
  logic               ivl_v_q, ivl_v_d;
  interval_t          ivl_q, ivl_d;
  logic               ivl_free;
  logic               in_free;
  logic [PROD_W-1:0]  prod;
  logic [MS_W-1:0]    on_ms;
  logic               frac_nz;

  assign ivl_free   = !ivl_v_q || ivl_ready_i;
  assign in_free    = !in_v_q || ivl_free;
  assign in_ready_o = in_free;

  // On time is the truncated product; off time is the period minus the
  // rounded-up product, which equals the truncated complement product
  assign prod    = PROD_W'(duty_q) * PROD_W'(period_ms_i);
  assign on_ms   = prod[FRAC_W +: MS_W];
  assign frac_nz = |prod[FRAC_W-1:0];

  always_comb begin
    ivl_d.on_ms  = on_ms;
    ivl_d.off_ms = period_ms_i - on_ms - MS_W'(frac_nz);
    ivl_d.now_ms = now_q;
  end

  // Advance valid bits of both stages
  assign in_v_d  = in_free ? in_valid_i : in_v_q;
  assign ivl_v_d = ivl_free ? in_v_q : ivl_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      ivl_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      ivl_v_q <= ivl_v_d;
    end
  end

  // Hold the input word, clamped on entry
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_free) begin
      duty_q <= clamp_duty(duty_i);
      now_q  <= now_ms_i;
    end
    if (in_v_q && ivl_free) begin
      ivl_q <= ivl_d;
    end
  end

  assign ivl_valid_o = ivl_v_q;
  assign ivl_o       = ivl_q;

endmodule

// ===== src/spwm_phase.sv =====
// ----------------------------------------------------------------------------
// spwm_phase
// Idle/high/low phase machine with minimum-interval override and result
// register.
// ----------------------------------------------------------------------------
module spwm_phase (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ivl_valid_i,
  output logic                       ivl_ready_o,
  input  spwm_pkg::interval_t        ivl_i,
  input  logic [spwm_pkg::MS_W-1:0]  min_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       drive_on_o
);
  import spwm_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d, phase_cur;
  logic [TIME_W-1:0] start_q, start_d, start_cur;
  logic              out_v_q, out_v_d;
  logic              drive_q, drive_d;
  logic              take;
  logic [TIME_W-1:0] on_end;
  logic [TIME_W-1:0] off_end;

  assign take        = !out_v_q || out_ready_i;
  assign ivl_ready_o = take;

  // An idle phase starts high at the current time
  assign phase_cur = (phase_q == PH_IDLE) ? PH_HIGH : phase_q;
  assign start_cur = (phase_q == PH_IDLE) ? ivl_i.now_ms : start_q;
  assign on_end    = start_cur + TIME_W'(ivl_i.on_ms);
  assign off_end   = start_cur + TIME_W'(ivl_i.off_ms);

  // Next phase and level for the word in front
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    drive_d = 1'b0;
    if (ivl_i.on_ms < min_ms_i) begin
      phase_d = PH_IDLE;
      drive_d = 1'b0;
    end else if (ivl_i.off_ms < min_ms_i) begin
      phase_d = PH_IDLE;
      drive_d = 1'b1;
    end else begin
      case (phase_cur)
        PH_HIGH: begin
          if (ivl_i.now_ms > on_end) begin
            phase_d = PH_LOW;
            start_d = ivl_i.now_ms;
            drive_d = 1'b0;
          end else begin
            phase_d = PH_HIGH;
            start_d = start_cur;
            drive_d = 1'b1;
          end
        end
        PH_LOW: begin
          if (ivl_i.now_ms > off_end) begin
            phase_d = PH_HIGH;
            start_d = ivl_i.now_ms;
            drive_d = 1'b1;
          end else begin
            drive_d = 1'b0;
          end
        end
        default: begin
          drive_d = 1'b0;
        end
      endcase
    end
  end

  assign out_v_d = take ? ivl_valid_i : out_v_q;

  // Commit state and result together when the word moves out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      start_q <= '0;
      out_v_q <= 1'b0;
      drive_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (ivl_valid_i && take) begin
        phase_q <= phase_d;
        start_q <= start_d;
        drive_q <= drive_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign drive_on_o  = drive_q;

endmodule

// ===== src/slow_pwm_with_min_pulse.sv =====
// ----------------------------------------------------------------------------
// slow_pwm_with_min_pulse
// Time-proportioning slow PWM with minimum on and off intervals.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_ready_o duty_i, now_ms_i
//   out      output     out_valid_o/out_ready_i drive_on_o
//   cfg      input      cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One word enters per cycle unless the output stalls; each result passes in turn
// through the three register stages (input, interval multiply, phase).
// A stalled output backs up through the stages to in_ready_o.
// Reset loads a 10 s period, a 1 s minimum and an idle phase.
// ----------------------------------------------------------------------------
module slow_pwm_with_min_pulse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [spwm_pkg::DUTY_W-1:0]    duty_i,
  input  logic [spwm_pkg::TIME_W-1:0]    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           drive_on_o,
  input  logic                           cfg_we_i,
  input  logic [spwm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spwm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import spwm_pkg::*;

`include "slow_pwm_with_min_pulse_defines.svh"

  logic [MS_W-1:0] period_ms;
  logic [MS_W-1:0] min_ms;
  logic            ivl_valid;
  logic            ivl_ready;
  interval_t       ivl;
  logic            ivl_fire;
  logic            short_on;
  logic            force_on;
  logic            out_stall;

  spwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .period_ms_o (period_ms),
    .min_ms_o    (min_ms)
  );

  spwm_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .duty_i      (duty_i),
    .now_ms_i    (now_ms_i),
    .period_ms_i (period_ms),
    .ivl_valid_o (ivl_valid),
    .ivl_ready_i (ivl_ready),
    .ivl_o       (ivl)
  );

  spwm_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ivl_valid_i (ivl_valid),
    .ivl_ready_o (ivl_ready),
    .ivl_i       (ivl),
    .min_ms_i    (min_ms),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_on_o  (drive_on_o)
  );

  assign ivl_fire  = ivl_valid && ivl_ready;
  assign short_on  = ivl.on_ms < min_ms;
  assign force_on  = !short_on && (ivl.off_ms < min_ms);
  assign out_stall = out_valid_o && !out_ready_i;

  // A short on time forces the output off
  `SPWM_ASSERT_NEXT(a_short_on_off, ivl_fire && short_on, !drive_on_o, "short on time not off")
  // A short off time with a long enough on time forces the output on
  `SPWM_ASSERT_NEXT(a_short_off_on, ivl_fire && force_on, drive_on_o, "short off time not on")
  // Input stalls only under output back-pressure
  `SPWM_ASSERT_NOW(a_stall_cause, !in_ready_o, out_stall, "input stall without back-pressure")
  // Every moved interval word produces a result next cycle
  `SPWM_ASSERT_NEXT(a_word_out, ivl_fire, out_valid_o, "interval word lost")

endmodule
